[hdl/pcm2f_pkg.sv]
package pcm2f_pkg;

    localparam int MAX_FRAME_BYTES = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [3:0] FMT_S8  = 4'd0;
    localparam logic [3:0] FMT_U8  = 4'd1;
    localparam logic [3:0] FMT_S16 = 4'd2;
    localparam logic [3:0] FMT_U16 = 4'd3;
    localparam logic [3:0] FMT_S24 = 4'd4;
    localparam logic [3:0] FMT_U24 = 4'd5;
    localparam logic [3:0] FMT_S32 = 4'd6;
    localparam logic [3:0] FMT_U32 = 4'd7;
    localparam logic [3:0] FMT_F32 = 4'd8;
    localparam logic [3:0] FMT_F64 = 4'd9;

    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_BIG_ENDIAN    = 2'd1;
    localparam logic [1:0] REG_STEREO_LAYOUT = 2'd2;

    typedef struct packed {
        logic [8*MAX_FRAME_BYTES-1:0] bytes;
        logic [3:0]                   fmt;
        logic                         big_endian;
        logic                         stereo;
    } frame_t;

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [30:0] base;
        logic [23:0] keep;
        logic        guard;
        logic        sticky;
    } round_t;

    function automatic logic [3:0] sample_size(input logic [3:0] fmt);
        logic [3:0] n;
        begin
            unique case (fmt) inside
                FMT_S8, FMT_U8:                   n = 4'd1;
                FMT_S16, FMT_U16:                 n = 4'd2;
                FMT_S24, FMT_U24:                 n = 4'd3;
                FMT_S32, FMT_U32, FMT_F32:        n = 4'd4;
                FMT_F64:                          n = 4'd8;
                default:                          n = 4'd1;
            endcase
            return n;
        end
    endfunction

    function automatic logic [8:0] scale_shift(input logic [3:0] fmt);
        logic [8:0] k;
        begin
            unique case (fmt) inside
                FMT_S8, FMT_U8:   k = 9'd7;
                FMT_S16, FMT_U16: k = 9'd15;
                FMT_S24, FMT_U24: k = 9'd23;
                default:          k = 9'd31;
            endcase
            return k;
        end
    endfunction

endpackage

[hdl/pcm2f_front.sv]
module pcm2f_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_buffer,
    input  logic                 full,
    output logic                 push,
    output pcm2f_pkg::frame_t    push_frame
);

    logic [3:0] fmt_reg;
    logic       be_reg;
    logic       stereo_reg;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] bytes_reg [pcm2f_pkg::MAX_FRAME_BYTES];

    logic       accept;
    logic [3:0] ss;
    logic [4:0] fs;
    logic [3:0] pos_inc;
    logic       complete;
    logic       cfg_hit;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign ss       = pcm2f_pkg::sample_size(fmt_reg);
    assign fs       = stereo_reg ? {ss, 1'b0} : {1'b0, ss};
    assign pos_inc  = pos_reg + 4'd1;
    // A sixteen-byte frame wraps the position back to zero.
    assign complete = (pos_inc == fs[3:0]);
    assign push     = accept && complete;

    always_comb
    begin
        for (int i = 0; i < pcm2f_pkg::MAX_FRAME_BYTES; i++)
        begin
            push_frame.bytes[8*i +: 8] = (4'(i) == pos_reg) ? data_byte : bytes_reg[i];
        end
        push_frame.fmt        = fmt_reg;
        push_frame.big_endian = be_reg;
        push_frame.stereo     = stereo_reg;
    end

    // Of the configuration writes, only one to an existing register discards the partial frame.
    always_comb
    begin
        unique case (cfg_index) inside
            pcm2f_pkg::REG_SAMPLE_FORMAT,
            pcm2f_pkg::REG_BIG_ENDIAN,
            pcm2f_pkg::REG_STEREO_LAYOUT: cfg_hit = cfg_we;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_hit)
        begin
            pos_next = 4'd0;
        end
        else if (accept)
        begin
            pos_next = (complete || end_of_buffer) ? 4'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= pcm2f_pkg::FMT_S16;
            be_reg     <= 1'b0;
            stereo_reg <= 1'b0;
            pos_reg    <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pcm2f_pkg::REG_SAMPLE_FORMAT: fmt_reg    <= cfg_data;
                    pcm2f_pkg::REG_BIG_ENDIAN:    be_reg     <= cfg_data[0];
                    pcm2f_pkg::REG_STEREO_LAYOUT: stereo_reg <= cfg_data[0];
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg[pos_reg] <= data_byte;
        end
    end

endmodule

[hdl/pcm2f_queue.sv]
module pcm2f_queue
#(
    parameter int DEPTH = pcm2f_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcm2f_pkg::frame_t push_frame,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output pcm2f_pkg::frame_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcm2f_pkg::frame_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("frame pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("frame popped from an empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 count_reg == $past(count_next))
        else $error("queue occupancy lost track");

endmodule

[hdl/pcm2f_back.sv]
module pcm2f_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  pcm2f_pkg::frame_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       sample_bits,
    output logic              channel,
    output logic              last_of_frame
);

    logic adv;
    logic take;
    logic idx_reg;

    // Stage 0: byte gathering
    logic [3:0]  n0;
    logic [3:0]  base0;
    logic [63:0] u0_next;
    logic        v0_reg;
    logic [63:0] u0_reg;
    logic [3:0]  fmt0_reg;
    logic        chan0_reg;
    logic        last0_reg;

    // Stage 1: integer value formation
    logic [32:0] d1_next;
    logic        v1_reg;
    logic [32:0] d1_reg;
    logic [63:0] u1_reg;
    logic [3:0]  fmt1_reg;
    logic        chan1_reg;
    logic        last1_reg;

    // Stage 2: normalisation
    pcm2f_pkg::round_t r2_next;
    pcm2f_pkg::round_t r2_reg;
    logic        v2_reg;
    logic        chan2_reg;
    logic        last2_reg;

    logic [31:0] bits3;
    logic        out_valid_reg;
    logic [31:0] sample_bits_reg;
    logic        channel_reg;
    logic        last_reg;

    assign adv  = !out_valid_reg || !out_stall;
    assign take = adv && q_valid;
    assign pop  = take && (idx_reg == head.stereo);

    assign out_valid     = out_valid_reg;
    assign sample_bits   = sample_bits_reg;
    assign channel       = channel_reg;
    assign last_of_frame = last_reg;

    always_comb
    begin
        logic [3:0] lidx;
        n0      = pcm2f_pkg::sample_size(head.fmt);
        base0   = idx_reg ? n0 : 4'd0;
        u0_next = '0;
        for (int j = 0; j < 8; j++)
        begin
            lidx = head.big_endian ? (base0 + n0 - 4'd1 - 4'(j)) : (base0 + 4'(j));
            if (4'(j) < n0)
            begin
                u0_next[8*j +: 8] = head.bytes[8*lidx +: 8];
            end
        end
    end

    // Unsigned 32-bit samples are first rounded to single precision, then the
    // midpoint is taken away; both steps round exactly as the float path would.
    always_comb
    begin
        logic [4:0]  p;
        logic [3:0]  sh;
        logic [23:0] kp;
        logic        g;
        logic        st;
        logic [24:0] kr;
        logic [32:0] r;
        p  = 5'd24;
        for (int i = 24; i < 32; i++)
        begin
            if (u0_reg[i])
            begin
                p = 5'(i);
            end
        end
        sh = 4'(p - 5'd23);
        kp = 24'(u0_reg[31:0] >> sh);
        g  = u0_reg[sh - 4'd1];
        st = |(u0_reg[31:0] & 32'((33'd1 << (sh - 4'd1)) - 33'd1));
        kr = {1'b0, kp} + 25'(g && (st || kp[0]));
        r  = (u0_reg[31:24] == 8'd0) ? {1'b0, u0_reg[31:0]} : (33'(kr) << sh);

        case (fmt0_reg)
            pcm2f_pkg::FMT_S8:  d1_next = {{25{u0_reg[7]}}, u0_reg[7:0]};
            pcm2f_pkg::FMT_S16: d1_next = {{17{u0_reg[15]}}, u0_reg[15:0]};
            pcm2f_pkg::FMT_S24: d1_next = {{9{u0_reg[23]}}, u0_reg[23:0]};
            pcm2f_pkg::FMT_S32: d1_next = {u0_reg[31], u0_reg[31:0]};
            pcm2f_pkg::FMT_U8:  d1_next = {25'd0, u0_reg[7:0]} - 33'd128;
            pcm2f_pkg::FMT_U16: d1_next = {17'd0, u0_reg[15:0]} - 33'd32768;
            pcm2f_pkg::FMT_U24: d1_next = {9'd0, u0_reg[23:0]} - 33'd8388608;
            pcm2f_pkg::FMT_U32: d1_next = r - 33'h080000000;
            default:            d1_next = '0;
        endcase
    end

    always_comb
    begin
        logic        sgn;
        logic [31:0] mag;
        logic [4:0]  p;
        logic [31:0] norm;
        logic [8:0]  ex;
        logic [10:0] e;
        logic [10:0] ee;
        logic [51:0] m;
        logic [52:0] sig;
        logic [5:0]  sh;
        logic [116:0] t;
        sgn  = d1_reg[32];
        mag  = sgn ? 32'(-d1_reg) : d1_reg[31:0];
        p    = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                p = 5'(i);
            end
        end
        norm = mag << (5'd31 - p);
        ex   = 9'(p) + 9'd127 - pcm2f_pkg::scale_shift(fmt1_reg);
        e    = u1_reg[62:52];
        m    = u1_reg[51:0];
        ee   = (e == 11'd0) ? 11'd1 : e;
        sig  = {(e != 11'd0), m};
        sh   = (ee >= 11'd897) ? 6'd29 : 6'(11'd926 - ee);
        t    = {sig, 64'd0} >> sh;

        r2_next             = '0;
        r2_next.special     = 1'b1;
        r2_next.special_val = 32'd0;
        case (fmt1_reg) inside
            pcm2f_pkg::FMT_S8, pcm2f_pkg::FMT_U8, pcm2f_pkg::FMT_S16, pcm2f_pkg::FMT_U16,
            pcm2f_pkg::FMT_S24, pcm2f_pkg::FMT_U24, pcm2f_pkg::FMT_S32, pcm2f_pkg::FMT_U32:
            begin
                if (mag != 32'd0)
                begin
                    r2_next.special = 1'b0;
                    r2_next.sign    = sgn;
                    r2_next.base    = {8'(ex - 9'd1), 23'd0};
                    r2_next.keep    = norm[31:8];
                    r2_next.guard   = norm[7];
                    r2_next.sticky  = |norm[6:0];
                end
            end
            pcm2f_pkg::FMT_F32:
            begin
                r2_next.special_val = u1_reg[31:0];
            end
            pcm2f_pkg::FMT_F64:
            begin
                if (e == 11'h7FF)
                begin
                    r2_next.special_val = (m == 52'd0) ? {u1_reg[63], 8'hFF, 23'd0}
                                                       : {u1_reg[63], 8'hFF, 1'b1, m[50:29]};
                end
                else if (ee >= 11'd1151)
                begin
                    r2_next.special_val = {u1_reg[63], 8'hFF, 23'd0};
                end
                else if (ee < 11'd866)
                begin
                    r2_next.special_val = {u1_reg[63], 31'd0};
                end
                else
                begin
                    r2_next.special = 1'b0;
                    r2_next.sign    = u1_reg[63];
                    r2_next.base    = (ee >= 11'd897) ? {8'(ee - 11'd897), 23'd0} : 31'd0;
                    r2_next.keep    = t[87:64];
                    r2_next.guard   = t[63];
                    r2_next.sticky  = |t[62:0];
                end
            end
            default:
            begin
                r2_next.special_val = 32'd0;
            end
        endcase
    end

    // The carry out of the mantissa rounds up into the exponent on its own.
    assign bits3 = r2_reg.special ? r2_reg.special_val
                 : {r2_reg.sign, r2_reg.base + {7'd0, r2_reg.keep}
                   + 31'(r2_reg.guard && (r2_reg.sticky || r2_reg.keep[0]))};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 1'b0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                idx_reg <= pop ? 1'b0 : 1'b1;
            end
            if (adv)
            begin
                v0_reg        <= take;
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u0_reg          <= u0_next;
            fmt0_reg        <= head.fmt;
            chan0_reg       <= idx_reg;
            last0_reg       <= (idx_reg == head.stereo);
            d1_reg          <= d1_next;
            u1_reg          <= u0_reg;
            fmt1_reg        <= fmt0_reg;
            chan1_reg       <= chan0_reg;
            last1_reg       <= last0_reg;
            r2_reg          <= r2_next;
            chan2_reg       <= chan1_reg;
            last2_reg       <= last1_reg;
            sample_bits_reg <= bits3;
            channel_reg     <= chan2_reg;
            last_reg        <= last2_reg;
        end
    end

endmodule

[hdl/pcm_sample_to_float_converter.sv]
// Channel   Handshake          Payload
// in        in_valid/in_stall  data_byte, end_of_buffer
// out       out_valid/out_stall sample_bits, channel, last_of_frame
// cfg       cfg_we             cfg_index, cfg_data
//
// One byte is taken per clock while the queue is not full; a stereo frame gives two
// samples in consecutive cycles unless the output stalls. A completed frame goes into
// the queue; each sample passes the back-end gather, value, normalise and round stages.
// Reset clears the frame position and loads the default format of signed 16-bit mono.
// The byte input stalls only while the frame queue is full; an output stall holds the
// back-end pipeline, and the queue absorbs frames meanwhile.
module pcm_sample_to_float_converter
#(
    parameter int QUEUE_DEPTH = pcm2f_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_bits,
    output logic        channel,
    output logic        last_of_frame
);

    logic              push;
    logic              pop;
    logic              full;
    logic              not_empty;
    pcm2f_pkg::frame_t push_frame;
    pcm2f_pkg::frame_t head;

    pcm2f_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .full          (full),
        .push          (push),
        .push_frame    (push_frame)
    );

    pcm2f_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    pcm2f_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (not_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_bits   (sample_bits),
        .channel       (channel),
        .last_of_frame (last_of_frame)
    );

endmodule
